// ===== hw/rtl/grid_box_candidate_query_macros.svh =====
// ----------------------------------------------------------------------------
// Grid box candidate query assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_BOX_CANDIDATE_QUERY_MACROS_SVH
`define GRID_BOX_CANDIDATE_QUERY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbq_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid box candidate query package
// Shared widths, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbq_pkg;

    localparam int COORD_W = 16;
    localparam int CSIZE_W = 16;
    localparam int ID_W    = 6;
    localparam int RAW_W   = 17;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SETUP,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_STP_WAIT,
        ST_EMIT,
        ST_ENT_ADV,
        ST_NEXT,
        ST_DONE
    } gbq_state_t;

endpackage

// ===== hw/rtl/grid_box_candidate_query.sv =====
// ----------------------------------------------------------------------------
// Grid box candidate query
// Uniform-grid index of boxes: clear, insert a box id, query candidate ids.
// Each operation takes one item at a time. The four corner divisions run in
// turn on the shared serial divider. Insert then visits each covered cell;
// query reads each covered cell and each stored id in it.
// Clear and reset run a counter clearing pass over all GRID_DIM*GRID_DIM cells;
// no item is taken during the pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_box_candidate_query_macros.svh"

module grid_box_candidate_query
#(
    parameter int GRID_DIM  = 16,
    parameter int CELL_CAP  = 8,
    parameter int MAX_BOXES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: cell_size.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // tdata: box_id[5:0], min_x[21:6], max_x[37:22], min_y[53:38],
    // max_y[69:54], zero fill [71:70].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    // tuser: op[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cand_id[5:0], zero fill [7:6].
    output logic [7:0]  m_axis_tdata,
    // tuser: found[0], status[1].
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int NCELLS    = GRID_DIM * GRID_DIM;
    localparam int CELL_W    = $clog2(NCELLS);
    localparam int GW        = $clog2(GRID_DIM);
    localparam int CNT_W     = $clog2(CELL_CAP + 1);
    localparam int ENT_DEPTH = NCELLS * CELL_CAP;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int SAW       = $clog2(MAX_BOXES);
    localparam int ID_W      = gbq_pkg::ID_W;
    localparam int CRD_W     = gbq_pkg::COORD_W;
    localparam int RAW_W     = gbq_pkg::RAW_W;
    localparam int STAMP_W   = gbq_pkg::STAMP_W;

    gbq_pkg::gbq_state_t state_reg, state_next;

    logic [gbq_pkg::CSIZE_W-1:0] cell_size_reg;
    logic [gbq_pkg::OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]             id_reg, id_next;
    logic signed [CRD_W-1:0]     crd_reg [4];
    logic signed [RAW_W-1:0]     raw_reg [4];
    logic [1:0]                  sel_reg, sel_next;
    logic [GW-1:0]               gx_reg, gx_next, gy_reg, gy_next;
    logic [GW-1:0]               gx0_reg, gx0_next, gx1_reg, gx1_next;
    logic [GW-1:0]               gy0_reg, gy0_next, gy1_reg, gy1_next;
    logic                        status_reg, status_next;
    logic [STAMP_W-1:0]          stamp_cnt_reg, stamp_cnt_next;
    logic [STAMP_W-1:0]          my_stamp_reg, my_stamp_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            ent_i_reg, ent_i_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]             pend_id_reg, pend_id_next;
    logic [CELL_W-1:0]           sweep_reg, sweep_next;
    logic                        sweep_rsp_reg, sweep_rsp_next;
    logic [MAX_BOXES-1:0]        stamp_vld_reg;

    logic                        out_vld_reg, out_vld_next;
    logic [ID_W-1:0]             out_id_reg, out_id_next;
    logic                        out_found_reg, out_found_next;
    logic                        out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;

    // Memories and their ports.
    logic [CNT_W-1:0]   cnt_mem [NCELLS];
    logic [ID_W-1:0]    ent_mem [ENT_DEPTH];
    logic [STAMP_W-1:0] stp_mem [MAX_BOXES];
    logic [CNT_W-1:0]   cnt_rdata_reg;
    logic [ID_W-1:0]    ent_rdata_reg;
    logic [STAMP_W-1:0] stp_rdata_reg;
    logic               cnt_we, cnt_re, ent_we, ent_re, stp_we, stp_re;
    logic [CELL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;

    logic               in_acc, out_free, div_start, div_done;
    logic signed [RAW_W-1:0] div_q;
    logic [CELL_W-1:0]  cell_idx;
    logic [ENT_AW-1:0]  ent_addr;
    logic [SAW-1:0]     cand_sel;
    logic               empty_box, id_bad, stp_hit, cell_full;
    logic [CNT_W-1:0]   n_cell, ent_i_inc;
    logic               stamp_clr_all;

    function automatic logic [GW-1:0] clamp_cell(input logic signed [RAW_W-1:0] q);
        logic [GW-1:0] r;
        if (q < 0)
            r = '0;
        else if (q > $signed(RAW_W'(GRID_DIM - 1)))
            r = GW'(GRID_DIM - 1);
        else
            r = q[GW-1:0];
        return r;
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == gbq_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;

    // Shared serial divider for the four corner coordinates.
    gbq_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .coord     (crd_reg[sel_reg]),
        .cell_size (cell_size_reg),
        .done      (div_done),
        .quot      (div_q)
    );

    // Address and compare logic.
    assign cell_idx  = CELL_W'(gx_reg) * CELL_W'(GRID_DIM) + CELL_W'(gy_reg);
    assign ent_addr  = ENT_AW'(cell_idx) * ENT_AW'(CELL_CAP) + ENT_AW'(ent_i_reg);
    assign cand_sel  = ent_rdata_reg[SAW-1:0];
    assign empty_box = (raw_reg[0] > raw_reg[1]) || (raw_reg[2] > raw_reg[3]);
    assign id_bad    = {1'b0, s_axis_tdata[ID_W-1:0]} >= (ID_W + 1)'(MAX_BOXES);
    assign stp_hit   = stamp_vld_reg[cand_sel] && (stp_rdata_reg == my_stamp_reg);
    assign cell_full = cnt_rdata_reg >= CNT_W'(CELL_CAP);
    assign n_cell    = cell_full ? CNT_W'(CELL_CAP) : cnt_rdata_reg;
    assign ent_i_inc = ent_i_reg + CNT_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbq_pkg::ST_SWEEP:
            begin
                if (sweep_reg == CELL_W'(NCELLS - 1))
                    state_next = sweep_rsp_reg ? gbq_pkg::ST_DONE : gbq_pkg::ST_IDLE;
            end
            gbq_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_axis_tuser)
                        gbq_pkg::OP_CLEAR:  state_next = gbq_pkg::ST_SWEEP;
                        gbq_pkg::OP_INSERT:
                            state_next = id_bad ? gbq_pkg::ST_DONE : gbq_pkg::ST_DIV_GO;
                        gbq_pkg::OP_QUERY:  state_next = gbq_pkg::ST_DIV_GO;
                        default:            state_next = gbq_pkg::ST_DONE;
                    endcase
                end
            end
            gbq_pkg::ST_DIV_GO:   state_next = gbq_pkg::ST_DIV_WAIT;
            gbq_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (sel_reg == 2'd3) ? gbq_pkg::ST_SETUP : gbq_pkg::ST_DIV_GO;
            end
            gbq_pkg::ST_SETUP:
                state_next = empty_box ? gbq_pkg::ST_DONE : gbq_pkg::ST_CNT_RD;
            gbq_pkg::ST_CNT_RD:   state_next = gbq_pkg::ST_CNT_WAIT;
            gbq_pkg::ST_CNT_WAIT:
            begin
                if (op_reg == gbq_pkg::OP_QUERY && n_cell != '0)
                    state_next = gbq_pkg::ST_ENT_RD;
                else
                    state_next = gbq_pkg::ST_NEXT;
            end
            gbq_pkg::ST_ENT_RD:   state_next = gbq_pkg::ST_ENT_WAIT;
            gbq_pkg::ST_ENT_WAIT: state_next = gbq_pkg::ST_STP_WAIT;
            gbq_pkg::ST_STP_WAIT:
            begin
                if (!stp_hit && pend_vld_reg)
                    state_next = gbq_pkg::ST_EMIT;
                else
                    state_next = gbq_pkg::ST_ENT_ADV;
            end
            gbq_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = gbq_pkg::ST_ENT_ADV;
            end
            gbq_pkg::ST_ENT_ADV:
                state_next = (ent_i_inc == n_reg) ? gbq_pkg::ST_NEXT : gbq_pkg::ST_ENT_RD;
            gbq_pkg::ST_NEXT:
            begin
                if (gy_reg == gy1_reg && gx_reg == gx1_reg)
                    state_next = gbq_pkg::ST_DONE;
                else
                    state_next = gbq_pkg::ST_CNT_RD;
            end
            gbq_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = gbq_pkg::ST_IDLE;
            end
            default: state_next = gbq_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory controls and results.
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        sel_next        = sel_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        gx0_next        = gx0_reg;
        gx1_next        = gx1_reg;
        gy0_next        = gy0_reg;
        gy1_next        = gy1_reg;
        status_next     = status_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        my_stamp_next   = my_stamp_reg;
        n_next          = n_reg;
        ent_i_next      = ent_i_reg;
        pend_vld_next   = pend_vld_reg;
        pend_id_next    = pend_id_reg;
        sweep_next      = sweep_reg;
        sweep_rsp_next  = sweep_rsp_reg;
        stamp_clr_all   = 1'b0;
        div_start       = 1'b0;
        cnt_we          = 1'b0;
        cnt_re          = 1'b0;
        cnt_waddr       = cell_idx;
        cnt_wdata       = cnt_rdata_reg + CNT_W'(1);
        ent_we          = 1'b0;
        ent_re          = 1'b0;
        stp_we          = 1'b0;
        stp_re          = 1'b0;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_id_next     = out_id_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            gbq_pkg::ST_SWEEP:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = sweep_reg;
                cnt_wdata  = '0;
                sweep_next = sweep_reg + CELL_W'(1);
            end
            gbq_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next       = s_axis_tuser;
                    id_next       = s_axis_tdata[ID_W-1:0];
                    sel_next      = 2'd0;
                    status_next   = (s_axis_tuser == gbq_pkg::OP_INSERT) && id_bad;
                    pend_vld_next = 1'b0;
                    if (s_axis_tuser == gbq_pkg::OP_CLEAR)
                    begin
                        stamp_clr_all  = 1'b1;
                        stamp_cnt_next = STAMP_W'(1);
                        sweep_next     = '0;
                        sweep_rsp_next = 1'b1;
                    end
                end
            end
            gbq_pkg::ST_DIV_GO:   div_start = 1'b1;
            gbq_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    sel_next = sel_reg + 2'd1;
            end
            gbq_pkg::ST_SETUP:
            begin
                gx0_next = clamp_cell(raw_reg[0]);
                gx1_next = clamp_cell(raw_reg[1]);
                gy0_next = clamp_cell(raw_reg[2]);
                gy1_next = clamp_cell(raw_reg[3]);
                gx_next  = clamp_cell(raw_reg[0]);
                gy_next  = clamp_cell(raw_reg[2]);
                // A wrapped stamp counter clears every stamp first.
                if (op_reg == gbq_pkg::OP_QUERY)
                begin
                    if (stamp_cnt_reg == '0)
                    begin
                        stamp_clr_all  = 1'b1;
                        my_stamp_next  = STAMP_W'(1);
                        stamp_cnt_next = STAMP_W'(2);
                    end
                    else
                    begin
                        my_stamp_next  = stamp_cnt_reg;
                        stamp_cnt_next = stamp_cnt_reg + STAMP_W'(1);
                    end
                end
            end
            gbq_pkg::ST_CNT_RD:   cnt_re = 1'b1;
            gbq_pkg::ST_CNT_WAIT:
            begin
                n_next     = n_cell;
                ent_i_next = '0;
                if (op_reg == gbq_pkg::OP_INSERT)
                begin
                    if (cell_full)
                        status_next = 1'b1;
                    else
                    begin
                        cnt_we = 1'b1;
                        ent_we = 1'b1;
                    end
                end
            end
            gbq_pkg::ST_ENT_RD:   ent_re = 1'b1;
            gbq_pkg::ST_ENT_WAIT: stp_re = 1'b1;
            gbq_pkg::ST_STP_WAIT:
            begin
                // A first visit marks the id and keeps it pending.
                if (!stp_hit)
                begin
                    stp_we = 1'b1;
                    if (!pend_vld_reg)
                    begin
                        pend_vld_next = 1'b1;
                        pend_id_next  = ent_rdata_reg;
                    end
                end
            end
            gbq_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_id_next     = pend_id_reg;
                    out_found_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_last_next   = 1'b0;
                    pend_id_next    = ent_rdata_reg;
                end
            end
            gbq_pkg::ST_ENT_ADV:  ent_i_next = ent_i_inc;
            gbq_pkg::ST_NEXT:
            begin
                if (gy_reg == gy1_reg)
                begin
                    gy_next = gy0_reg;
                    gx_next = gx_reg + GW'(1);
                end
                else
                    gy_next = gy_reg + GW'(1);
            end
            gbq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_id_next     = pend_vld_reg ? pend_id_reg : '0;
                    out_found_next  = pend_vld_reg;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    sweep_rsp_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbq_pkg::ST_SWEEP;
            cell_size_reg <= 16'd2048;
            sweep_reg     <= '0;
            sweep_rsp_reg <= 1'b0;
            stamp_cnt_reg <= STAMP_W'(1);
            stamp_vld_reg <= '0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            op_reg        <= gbq_pkg::OP_CLEAR;
            sel_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            sweep_rsp_reg <= sweep_rsp_next;
            stamp_cnt_reg <= stamp_cnt_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
            op_reg        <= op_next;
            sel_reg       <= sel_next;
            if (cfg_valid && cfg_ready)
                cell_size_reg <= cfg_data;
            if (stamp_clr_all)
                stamp_vld_reg <= '0;
            else if (stp_we)
                stamp_vld_reg[cand_sel] <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        gx0_reg        <= gx0_next;
        gx1_reg        <= gx1_next;
        gy0_reg        <= gy0_next;
        gy1_reg        <= gy1_next;
        status_reg     <= status_next;
        my_stamp_reg   <= my_stamp_next;
        n_reg          <= n_next;
        ent_i_reg      <= ent_i_next;
        pend_id_reg    <= pend_id_next;
        out_id_reg     <= out_id_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (in_acc)
        begin
            crd_reg[0] <= s_axis_tdata[ID_W +: CRD_W];
            crd_reg[1] <= s_axis_tdata[ID_W + CRD_W +: CRD_W];
            crd_reg[2] <= s_axis_tdata[ID_W + 2 * CRD_W +: CRD_W];
            crd_reg[3] <= s_axis_tdata[ID_W + 3 * CRD_W +: CRD_W];
        end
        if (state_reg == gbq_pkg::ST_DIV_WAIT && div_done)
            raw_reg[sel_reg] <= div_q;
    end

    // Per-cell id counts.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cell_idx];
    end

    // Per-cell id slots.
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ENT_AW'(cell_idx) * ENT_AW'(CELL_CAP) + ENT_AW'(cnt_rdata_reg)] <= id_reg;
        if (ent_re)
            ent_rdata_reg <= ent_mem[ent_addr];
    end

    // Per-id visit stamps; an entry without its valid bit never counts as a hit.
    always_ff @(posedge clk)
    begin
        if (stp_we)
            stp_mem[cand_sel] <= my_stamp_reg;
        if (stp_re)
            stp_rdata_reg <= stp_mem[ent_rdata_reg[SAW-1:0]];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_id_reg};
    assign m_axis_tuser  = {out_status_reg, out_found_reg};
    assign m_axis_tlast  = out_last_reg;

    // Checks on the sequencer and result formation.
    `GBQ_ASSERT_NEXT(a_stamp_nonzero, state_reg == gbq_pkg::ST_SETUP && op_reg == gbq_pkg::OP_QUERY, my_stamp_reg != '0, "query stamp is zero")
    `GBQ_ASSERT_NOW(a_count_cap, state_reg == gbq_pkg::ST_CNT_WAIT, cnt_rdata_reg <= CNT_W'(CELL_CAP), "cell count above capacity")
    `GBQ_ASSERT_NOW(a_found_clean, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "candidate carries status")
    `GBQ_ASSERT_NOW(a_nofound_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0, "empty result has nonzero id")

endmodule

// ===== hw/rtl/gbq_div.sv =====
// ----------------------------------------------------------------------------
// Grid box candidate query floor divider
// Restoring divider, one quotient bit per cycle, giving floor(coord / size).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbq_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gbq_pkg::COORD_W-1:0]  coord,
    input  logic        [gbq_pkg::CSIZE_W-1:0]  cell_size,
    output logic                                done,
    output logic signed [gbq_pkg::RAW_W-1:0]    quot
);

    localparam int W    = gbq_pkg::COORD_W;
    localparam int CW   = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] step_reg, step_next;
    logic          neg_reg, neg_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  divisor;
    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;

    // A zero cell size acts as one.
    assign divisor = (cell_size == '0) ? W'(1) : cell_size;

    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, divisor};

    // For a negative coordinate, floor(c / d) equals ~(~c / d).
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = coord[W-1];
            rem_next  = '0;
            quo_next  = coord[W-1] ? ~coord : coord;
        end
        else if (busy_reg)
        begin
            if (diff[W+1])
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[W:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            step_next = step_reg + CW'(1);
            if (step_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~{1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule
